// ----- sv/u2u8_pkg.sv -----
// Shared constants, types and byte-building functions for the UTF-16 to UTF-8 encoder.
package u2u8_pkg;

	localparam logic [15:0] HI_FIRST     = 16'hD800;
	localparam logic [15:0] HI_LAST      = 16'hDBFF;
	localparam logic [15:0] LO_FIRST     = 16'hDC00;
	localparam logic [15:0] LO_LAST      = 16'hDFFF;
	localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
	localparam logic [7:0]  LEAD2        = 8'hC0;
	localparam logic [7:0]  LEAD3        = 8'hE0;
	localparam logic [7:0]  LEAD4        = 8'hF0;
	localparam logic [7:0]  TRAIL        = 8'h80;
	localparam logic [20:0] PLANE1       = 21'h10000;

	// ASCII '%', and the offsets that map a nibble to "0123456789ABCDEF".
	localparam logic [7:0]  PERCENT_CHAR    = 8'h25;
	localparam logic [7:0]  HEX_DIGIT_BASE  = 8'h30;
	localparam logic [7:0]  HEX_LETTER_BASE = 8'h37;

	// Most UTF-8 bytes one code unit can cause.
	localparam int MAX_BYTES = 6;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      len;
	} unit_t;

	// Result of encoding one code unit: bytes in order from index 0.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
		logic [15:0]               next_pending;
	} enc_t;

	function automatic byte_t hex_char(input logic [3:0] d);
		byte_t c;
		if (d < 4'd10) begin
			c = HEX_DIGIT_BASE + {4'h0, d};
		end else begin
			c = HEX_LETTER_BASE + {4'h0, d};
		end
		return c;
	endfunction

	function automatic logic [2:0][7:0] put_three(input logic [15:0] x);
		logic [2:0][7:0] t;
		t[0] = LEAD3 | {4'h0, x[15:12]};
		t[1] = TRAIL | {2'b00, x[11:6]};
		t[2] = TRAIL | {2'b00, x[5:0]};
		return t;
	endfunction

	function automatic unit_t put_unit(input logic [15:0] u);
		unit_t r;
		r = '0;
		if (u <= ONE_BYTE_MAX) begin
			r.bytes[0] = u[7:0];
			r.len      = 2'd1;
		end else if (u <= TWO_BYTE_MAX) begin
			r.bytes[0] = LEAD2 | {3'b000, u[10:6]};
			r.bytes[1] = TRAIL | {2'b00, u[5:0]};
			r.len      = 2'd2;
		end else begin
			r.bytes = put_three(u);
			r.len   = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [3:0][7:0] put_pair(input logic [15:0] hi, input logic [15:0] lo);
		logic [20:0]     cp;
		logic [3:0][7:0] p;
		cp   = {1'b0, hi[9:0], lo[9:0]} + PLANE1;
		p[0] = LEAD4 | {5'b00000, cp[20:18]};
		p[1] = TRAIL | {2'b00, cp[17:12]};
		p[2] = TRAIL | {2'b00, cp[11:6]};
		p[3] = TRAIL | {2'b00, cp[5:0]};
		return p;
	endfunction

endpackage

// ----- sv/u2u8_encode.sv -----
// Turns one UTF-16 code unit and the held high surrogate into up to six UTF-8 bytes.
module u2u8_encode (
	input  logic [15:0]     code_unit,
	input  logic            end_of_string,
	input  logic [15:0]     pending,
	output u2u8_pkg::enc_t  enc
);

	logic           is_hi;
	logic           is_lo;
	logic           held;
	u2u8_pkg::unit_t unit;

	assign is_hi = (code_unit >= u2u8_pkg::HI_FIRST) && (code_unit <= u2u8_pkg::HI_LAST);
	assign is_lo = (code_unit >= u2u8_pkg::LO_FIRST) && (code_unit <= u2u8_pkg::LO_LAST);
	assign held  = (pending != 16'h0000);
	assign unit  = u2u8_pkg::put_unit(code_unit);

	always_comb begin
		enc = '0;
		priority if (is_hi) begin
			// The old surrogate, if any, goes out first; the new one is flushed
			// right behind it when the string ends here.
			enc.bytes[2:0] = held ? u2u8_pkg::put_three(pending)
			                      : u2u8_pkg::put_three(code_unit);
			enc.bytes[5:3] = u2u8_pkg::put_three(code_unit);
			if (held && end_of_string) begin
				enc.count = 3'd6;
			end else if (held || end_of_string) begin
				enc.count = 3'd3;
			end else begin
				enc.count = 3'd0;
			end
			enc.next_pending = end_of_string ? 16'h0000 : code_unit;
		end else if (held && is_lo) begin
			enc.bytes[3:0] = u2u8_pkg::put_pair(pending, code_unit);
			enc.count      = 3'd4;
		end else if (held) begin
			enc.bytes[2:0] = u2u8_pkg::put_three(pending);
			enc.bytes[5:3] = unit.bytes;
			enc.count      = 3'd3 + {1'b0, unit.len};
		end else begin
			enc.bytes[2:0] = unit.bytes;
			enc.count      = {1'b0, unit.len};
		end
	end

endmodule

// ----- sv/utf16_to_utf8_percent_encoder.sv -----
// Top level of the UTF-16 to UTF-8 encoder with optional percent escaping.
//
// Each input word is one UTF-16 code unit plus an end-of-string flag; each output
// word is one character, with last_of_run marking the final character caused by
// one input word. A high surrogate is held until the next unit: a low surrogate
// completes a 4-byte sequence, anything else (or the end of the string) sends the
// held surrogate out alone as 3 bytes. With escape_mode set (the reset value),
// every UTF-8 byte leaves as '%' and two upper-case hex digits, else as a raw byte.
// Flow: the output channel carries one character per cycle while out_stall is low;
// an input word causes between 0 and 6 bytes, each sent as three characters in
// escape mode and as one in raw mode. A word that causes no character (a held high
// surrogate) leaves the serializer empty and does not hold up the next word. The
// next word is taken in the same cycle that the last character of the current one
// moves into the output register, so the character serializer, not the encoder,
// sets the rate. The user must write escape_mode only while the block is idle; the
// block itself does not enforce this.
module utf16_to_utf8_percent_encoder (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last_of_run
);

	// Position inside one escaped byte: '%', high nibble, low nibble.
	localparam logic [1:0] PH_PCT = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_LO  = 2'd2;

	logic                                escape_q;
	logic [15:0]                         pending_q;
	logic [u2u8_pkg::MAX_BYTES-1:0][7:0] buf_q;
	logic [2:0]                          cnt_q;
	logic [1:0]                          phase_q;
	logic                                out_valid_q;
	logic [7:0]                          out_char_q;
	logic                                last_q;

	u2u8_pkg::enc_t enc;
	logic           accept;
	logic           out_free;
	logic           emit;
	logic           byte_done;
	logic           last_char;
	logic [7:0]     cur_char;

	u2u8_encode u_encode (
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.pending       (pending_q),
		.enc           (enc)
	);

	// The output register frees up when it is empty or its word leaves now.
	assign out_free  = !out_valid_q || !out_stall;
	// The serializer holds bytes still to be sent while cnt_q is nonzero.
	assign emit      = (cnt_q != 3'd0) && out_free;
	assign byte_done = !escape_q || (phase_q == PH_LO);
	assign last_char = byte_done && (cnt_q == 3'd1);

	// A new word is taken when the serializer is empty or is handing over its
	// final character in this very cycle.
	assign in_stall  = (cnt_q != 3'd0) && !(out_free && last_char);
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cur_char = buf_q[0];
		if (escape_q) begin
			unique case (phase_q)
				PH_PCT:  cur_char = u2u8_pkg::PERCENT_CHAR;
				PH_HI:   cur_char = u2u8_pkg::hex_char(buf_q[0][7:4]);
				PH_LO:   cur_char = u2u8_pkg::hex_char(buf_q[0][3:0]);
				default: cur_char = u2u8_pkg::PERCENT_CHAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b1;
		end else if (cfg_wr_en) begin
			escape_q <= cfg_wr_data;
		end
	end

	// Surrogate hold and serializer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 16'h0000;
			cnt_q     <= 3'd0;
			phase_q   <= PH_PCT;
		end else if (accept) begin
			pending_q <= enc.next_pending;
			cnt_q     <= enc.count;
			phase_q   <= PH_PCT;
		end else if (emit) begin
			if (byte_done) begin
				cnt_q   <= cnt_q - 3'd1;
				phase_q <= PH_PCT;
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// Byte buffer: the byte being sent always sits at index 0.
	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= enc.bytes;
		end else if (emit && byte_done) begin
			buf_q <= {8'h00, buf_q[u2u8_pkg::MAX_BYTES-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= cur_char;
			last_q     <= last_char;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd6)
		else $error("byte count beyond six");

	a_pending_high: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 16'h0000) ||
		((pending_q >= u2u8_pkg::HI_FIRST) && (pending_q <= u2u8_pkg::HI_LAST)))
		else $error("held unit is not a high surrogate");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_char && !accept) |=> (cnt_q == 3'd0))
		else $error("serializer not empty after final character");

	a_raw_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!escape_q |-> (phase_q == PH_PCT))
		else $error("escape phase advanced in raw mode");
`endif

endmodule
